@@ rtl/core/fpalu_pkg.sv @@
// ----------------------------------------------------------------------------
// fpalu_pkg: shared types and constants of the fixed-point ALU
// Transaction payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int REM_W     = NUM_W + 1;
  localparam int DIV_STEPS = DATA_W;

  localparam logic [3:0] MODE_ADD     = 4'd0;
  localparam logic [3:0] MODE_SUB     = 4'd1;
  localparam logic [3:0] MODE_MUL     = 4'd2;
  localparam logic [3:0] MODE_DIV     = 4'd3;
  localparam logic [3:0] MODE_GT      = 4'd4;
  localparam logic [3:0] MODE_LT      = 4'd5;
  localparam logic [3:0] MODE_GE      = 4'd6;
  localparam logic [3:0] MODE_LE      = 4'd7;
  localparam logic [3:0] MODE_EQ      = 4'd8;
  localparam logic [3:0] MODE_NE      = 4'd9;
  localparam logic [3:0] MODE_MIN     = 4'd10;
  localparam logic [3:0] MODE_MAX     = 4'd11;
  localparam logic [3:0] MODE_TOINT   = 4'd12;
  localparam logic [3:0] MODE_INC     = 4'd13;
  localparam logic [3:0] MODE_DEC     = 4'd14;
  localparam logic [3:0] MODE_FROMINT = 4'd15;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_DIV0 = 2'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     compare_true;
    logic [1:0]               status;
  } alu_out_t;

endpackage

@@ rtl/core/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, increment, decrement and convert on raw signed values.
// ----------------------------------------------------------------------------
// Usage:
//   An operation enters on the in channel (in_valid_i / in_ready_o) with its
//   mode and two raw operands, and its result leaves on the out channel
//   (out_valid_o / out_ready_i) with the result, compare flag and status.
//   Every operation takes the same path, so results leave in input order.
//   The pipeline has one operand stage with the 32x32 multiplier and the
//   adders, 32 restoring divider stages (one quotient bit each), and a
//   rounding, saturation and output stage. The divider chain sets the depth.
//   Throughput is one transaction per cycle while the output is not stalled.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated. Reset clears all
//   valid bits, so the pipeline starts empty.
// ----------------------------------------------------------------------------
module fixed_point_alu
  import fpalu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  alu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output alu_out_t out_data_o
);

  typedef struct packed {
    logic                     valid;
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] small_res;
    logic [1:0]               small_st;
    logic                     cmp;
    logic signed [63:0]       prod;
    logic                     neg;
    logic                     big;
    logic                     dzero;
    logic                     sign_a;
    logic [DATA_W-1:0]        den;
    logic [REM_W-1:0]         rem;
    logic [DATA_W-1:0]        quo;
  } stage_t;

  stage_t   pipe_q [DIV_STEPS+1];
  stage_t   pipe_d [1:DIV_STEPS];
  stage_t   op_d;
  logic     out_valid_q;
  alu_out_t out_q;
  alu_out_t out_d;
  logic     adv;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Operand stage.
  always_comb begin
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W:0]          sum;
    logic [DATA_W:0]          dif;
    logic [NUM_W-1:0]         fi;
    logic [DATA_W-1:0]        maga;
    logic [NUM_W-1:0]         num;
    a = in_data_i.operand_a;
    b = in_data_i.operand_b;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    dif = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    fi = {a, {FRAC_BITS{1'b0}}};
    maga = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    num = {maga, {FRAC_BITS{1'b0}}};

    op_d          = '0;
    op_d.valid    = in_valid_i;
    op_d.mode     = in_data_i.mode;
    op_d.small_st = STATUS_OK;
    op_d.prod     = 64'(a) * 64'(b);
    op_d.neg      = a[DATA_W-1] ^ b[DATA_W-1];
    op_d.sign_a   = a[DATA_W-1];
    op_d.den      = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
    op_d.dzero    = (b == '0);
    op_d.rem      = REM_W'(num);
    // A quotient of 2^32 or more always saturates; the divider only forms
    // the low 32 bits.
    op_d.big      = 64'(num) >= {op_d.den, 32'h0};

    case (in_data_i.mode)
      MODE_ADD, MODE_SUB: begin
        if (in_data_i.mode == MODE_ADD) begin
          op_d.small_res = sum[DATA_W-1:0];
          if (sum[DATA_W] != sum[DATA_W-1]) begin
            op_d.small_res = sum[DATA_W] ? SAT_MIN : SAT_MAX;
            op_d.small_st  = STATUS_OVF;
          end
        end else begin
          op_d.small_res = dif[DATA_W-1:0];
          if (dif[DATA_W] != dif[DATA_W-1]) begin
            op_d.small_res = dif[DATA_W] ? SAT_MIN : SAT_MAX;
            op_d.small_st  = STATUS_OVF;
          end
        end
      end
      MODE_GT: op_d.cmp = a > b;
      MODE_LT: op_d.cmp = a < b;
      MODE_GE: op_d.cmp = a >= b;
      MODE_LE: op_d.cmp = a <= b;
      MODE_EQ: op_d.cmp = a == b;
      MODE_NE: op_d.cmp = a != b;
      MODE_MIN: op_d.small_res = (a <= b) ? a : b;
      MODE_MAX: op_d.small_res = (a >= b) ? a : b;
      MODE_TOINT: op_d.small_res = a >>> FRAC_BITS;
      MODE_INC: op_d.small_res = a + DATA_W'(1);
      MODE_DEC: op_d.small_res = a - DATA_W'(1);
      MODE_FROMINT: begin
        op_d.small_res = fi[DATA_W-1:0];
        // The shifted-out bits and the new sign bit must all agree.
        if (fi[NUM_W-1:DATA_W-1] != '0 && fi[NUM_W-1:DATA_W-1] != '1) begin
          op_d.small_res = a[DATA_W-1] ? SAT_MIN : SAT_MAX;
          op_d.small_st  = STATUS_OVF;
        end
      end
      default: ;
    endcase
  end

  // Restoring divider: stage k decides quotient bit DIV_STEPS-k.
  always_comb begin
    logic [63:0] dsh;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      pipe_d[k] = pipe_q[k-1];
      dsh = 64'(pipe_q[k-1].den) << (DIV_STEPS - k);
      if (64'(pipe_q[k-1].rem) >= dsh) begin
        pipe_d[k].rem = pipe_q[k-1].rem - REM_W'(dsh);
        pipe_d[k].quo[DIV_STEPS-k] = 1'b1;
      end
    end
  end

  // Rounding, saturation and result selection.
  always_comb begin
    stage_t      s;
    logic        up;
    logic [32:0] q;
    logic        dsat;
    logic [63:0] pmag;
    logic [63:0] m;
    logic        msat;
    s    = pipe_q[DIV_STEPS];
    up   = (64'(s.rem) << 1) >= 64'(s.den);
    q    = {1'b0, s.quo} + 33'(up);
    dsat = s.big || (s.neg ? (q > 33'h0_8000_0000) : (q > 33'h0_7FFF_FFFF));
    pmag = s.prod[63] ? 64'(-s.prod) : 64'(s.prod);
    m    = (pmag + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    msat = s.prod[63] ? (m > 64'h8000_0000) : (m > 64'h7FFF_FFFF);

    out_d.result       = s.small_res;
    out_d.compare_true = s.cmp;
    out_d.status       = s.small_st;
    case (s.mode)
      MODE_MUL: begin
        if (msat) begin
          out_d.result = s.prod[63] ? SAT_MIN : SAT_MAX;
          out_d.status = STATUS_OVF;
        end else begin
          out_d.result = s.prod[63] ? -m[DATA_W-1:0] : m[DATA_W-1:0];
        end
      end
      MODE_DIV: begin
        if (s.dzero) begin
          out_d.result = s.sign_a ? SAT_MIN : SAT_MAX;
          out_d.status = STATUS_DIV0;
        end else if (dsat) begin
          out_d.result = s.neg ? SAT_MIN : SAT_MAX;
          out_d.status = STATUS_OVF;
        end else begin
          out_d.result = s.neg ? -q[DATA_W-1:0] : q[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        pipe_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pipe_q[0] <= op_d;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
      out_valid_q <= pipe_q[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the output is stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != 2'd3))
    else $error("undefined status code");

  a_compare_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.compare_true) |->
      (out_data_o.result == '0 && out_data_o.status == STATUS_OK))
    else $error("compare result with nonzero value or status");

  a_div0_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STATUS_DIV0) |->
      (out_data_o.result == SAT_MAX || out_data_o.result == SAT_MIN))
    else $error("divide by zero without saturation");
`endif

endmodule
